// ----- rtl/jsu_pkg.sv -----
package jsu_pkg;

   typedef enum logic [1:0] {
      MODE_TEXT = 2'd0,
      MODE_ESC  = 2'd1,
      MODE_HEX  = 2'd2
   } mode_type;

   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [2:0] HEX_HOLD    = 3'd3;

   // up to three output bytes produced by one input beat
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      num;
      logic            mark;
      logic            last;
   } entry_type;

   typedef struct packed {
      logic full;
      logic avail;
   } qstat_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] ch;
      logic       is_u;
   } esc_type;

   function automatic esc_type esc_char(input logic [7:0] c);
      esc_type r;
      r.hit  = 1'b1;
      r.ch   = c;
      r.is_u = 1'b0;
      if (c == CHAR_N || c == CHAR_T) begin
         r.ch = CHAR_SPACE;
      end else if (c == CHAR_R) begin
         r.hit = 1'b0;
      end else if (c == CHAR_U) begin
         r.hit  = 1'b0;
         r.is_u = 1'b1;
      end
      return r;
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_nib(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

// ----- rtl/jsu_front.sv -----
module jsu_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           in_byte,
   input  logic                 in_last,
   output logic                 push,
   output jsu_pkg::entry_type   entry
);

   jsu_pkg::mode_type mode_ff, mode_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic [2:0][7:0]   held_ff;

   logic [2:0][7:0]   hn;
   logic [3:0][7:0]   ob;
   logic [1:0]        n;
   logic [1:0]        nc;
   logic [4:0]        x0, x1, x2, x3;
   logic [15:0]       cp;
   jsu_pkg::esc_type  e0, e1, e2;

   always_comb begin
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         unique case (mode_ff)
            jsu_pkg::MODE_ESC: begin
               mode_in = e0.is_u ? jsu_pkg::MODE_HEX : jsu_pkg::MODE_TEXT;
               cnt_in  = 3'd0;
            end
            jsu_pkg::MODE_HEX: begin
               if (cnt_ff < jsu_pkg::HEX_HOLD) begin
                  cnt_in = cnt_ff + 3'd1;
               end else begin
                  mode_in = jsu_pkg::MODE_TEXT;
                  cnt_in  = 3'd0;
               end
            end
            default: begin
               mode_in = (in_byte == jsu_pkg::CHAR_BSLASH && !in_last) ?
                         jsu_pkg::MODE_ESC : jsu_pkg::MODE_TEXT;
            end
         endcase
         if (in_last) begin
            mode_in = jsu_pkg::MODE_TEXT;
            cnt_in  = 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= jsu_pkg::MODE_TEXT;
         cnt_ff  <= 3'd0;
      end else begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && mode_ff == jsu_pkg::MODE_HEX && cnt_ff < jsu_pkg::HEX_HOLD) begin
         held_ff[cnt_ff[1:0]] <= in_byte;
      end
   end

   // held characters with the current beat folded in
   always_comb begin
      hn = held_ff;
      if (cnt_ff < jsu_pkg::HEX_HOLD) begin
         hn[cnt_ff[1:0]] = in_byte;
      end
      nc = cnt_ff[1:0] + 2'd1;
   end

   assign e0 = jsu_pkg::esc_char(in_byte);
   assign e1 = jsu_pkg::esc_char(hn[1]);
   assign e2 = jsu_pkg::esc_char(hn[2]);

   assign x0 = jsu_pkg::hex_nib(held_ff[0]);
   assign x1 = jsu_pkg::hex_nib(held_ff[1]);
   assign x2 = jsu_pkg::hex_nib(held_ff[2]);
   assign x3 = jsu_pkg::hex_nib(in_byte);

   // digits up to the first non-hex character
   always_comb begin
      priority if (!x0[4]) cp = 16'd0;
      else if (!x1[4])     cp = {12'd0, x0[3:0]};
      else if (!x2[4])     cp = {8'd0, x0[3:0], x1[3:0]};
      else if (!x3[4])     cp = {4'd0, x0[3:0], x1[3:0], x2[3:0]};
      else                 cp = {x0[3:0], x1[3:0], x2[3:0], x3[3:0]};
   end

   always_comb begin
      ob = '0;
      n  = 2'd0;
      unique case (mode_ff)
         jsu_pkg::MODE_ESC: begin
            if (e0.hit) begin
               ob[n] = e0.ch; n = n + 2'd1;
            end
         end
         jsu_pkg::MODE_HEX: begin
            if (cnt_ff < jsu_pkg::HEX_HOLD) begin
               if (in_last) begin
                  // string ended inside a u escape: rescan what was held
                  if (hn[0] == jsu_pkg::CHAR_BSLASH && nc >= 2'd2) begin
                     if (e1.hit) begin
                        ob[n] = e1.ch; n = n + 2'd1;
                     end
                     if (nc == 2'd3) begin
                        ob[n] = hn[2]; n = n + 2'd1;
                     end
                  end else begin
                     ob[n] = hn[0]; n = n + 2'd1;
                     if (nc >= 2'd2) begin
                        if (hn[1] == jsu_pkg::CHAR_BSLASH && nc == 2'd3) begin
                           if (e2.hit) begin
                              ob[n] = e2.ch; n = n + 2'd1;
                           end
                        end else begin
                           ob[n] = hn[1]; n = n + 2'd1;
                           if (nc == 2'd3) begin
                              ob[n] = hn[2]; n = n + 2'd1;
                           end
                        end
                     end
                  end
               end
            end else if (cp < 16'h0080) begin
               if (cp != 16'd9) begin
                  ob[n] = cp[7:0]; n = n + 2'd1;
               end
            end else if (cp < 16'h0800) begin
               ob[0] = 8'hC0 | {3'd0, cp[10:6]};
               ob[1] = 8'h80 | {2'd0, cp[5:0]};
               n     = 2'd2;
            end else begin
               ob[0] = 8'hE0 | {4'd0, cp[15:12]};
               ob[1] = 8'h80 | {2'd0, cp[11:6]};
               ob[2] = 8'h80 | {2'd0, cp[5:0]};
               n     = 2'd3;
            end
         end
         default: begin
            if (!(in_byte == jsu_pkg::CHAR_BSLASH && !in_last)) begin
               ob[n] = in_byte; n = n + 2'd1;
            end
         end
      endcase

      entry.bytes = ob[2:0];
      entry.num   = (n == 2'd0) ? 2'd1 : n;
      entry.mark  = (n == 2'd0);
      entry.last  = in_last;
      push        = accept && (n != 2'd0 || in_last);
   end

endmodule

// ----- rtl/jsu_queue.sv -----
module jsu_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  jsu_pkg::entry_type   wr_entry,
   input  logic                 pop,
   output jsu_pkg::entry_type   rd_entry,
   output jsu_pkg::qstat_type   stat
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   jsu_pkg::entry_type mem_ff [DEPTH];
   logic [PW-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]      count_ff, count_in;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= wr_entry;
      end
   end

   assign rd_entry   = mem_ff[rd_ff];
   assign stat.full  = (count_ff == CW'(DEPTH));
   assign stat.avail = (count_ff != '0);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !stat.full) else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> stat.avail) else $error("queue read while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

// ----- rtl/jsu_back.sv -----
module jsu_back (
   input  logic                 clock,
   input  logic                 reset,
   input  jsu_pkg::entry_type   head,
   input  jsu_pkg::qstat_type   stat,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_byte_valid,
   output logic                 rsp_out_last
);

   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic [7:0] byte_ff;
   logic       bval_ff, last_ff;
   logic       load, tail;

   assign load = !valid_ff || !rsp_stall;
   assign tail = (idx_ff == head.num - 2'd1);
   assign pop  = load && stat.avail && tail;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = stat.avail;
         if (stat.avail) begin
            idx_in = tail ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && stat.avail) begin
         byte_ff <= head.bytes[idx_ff];
         bval_ff <= !head.mark;
         last_ff <= head.last && tail;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_byte_valid = bval_ff;
   assign rsp_out_last   = last_ff;

   a_idx_restart: assert property (@(posedge clock) disable iff (reset)
      pop |=> idx_ff == 2'd0) else $error("beat index not restarted after pop");

endmodule

// ----- rtl/json_string_unescape_utf8.sv -----
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_stall  req_in_byte, req_in_last
// rsp      out        rsp_valid / rsp_stall  rsp_out_byte, rsp_byte_valid, rsp_out_last
//
// One input beat per cycle unless req_stall holds it; a beat yields 0 to 3 bytes, and
// the last beat of a string always yields at least one (an end marker if nothing else).
// The back end drains one output byte per cycle unless rsp_stall holds it, from a
// QUEUE_DEPTH-entry queue; req_stall rises only while that queue is full, i.e. while
// expansion or rsp_stall outruns the drain. Bytes pass the queue, then a register.
// Synchronous reset returns the parser to plain text and empties the queue.
module json_string_unescape_utf8 #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_out_last
);

   jsu_pkg::entry_type wr_entry, head;
   jsu_pkg::qstat_type stat;
   logic               accept, push, pop;

   assign req_stall = stat.full;
   assign accept    = req_valid && !req_stall;

   jsu_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .in_last (req_in_last),
      .push    (push),
      .entry   (wr_entry)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_entry (wr_entry),
      .pop      (pop),
      .rd_entry (head),
      .stat     (stat)
   );

   jsu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .stat           (stat),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_out_last   (rsp_out_last)
   );

endmodule

// ----- verif/testbench.sv -----
localparam logic [15:0] CP_TAB = 16'h0009;  // code point that the unescaper drops

class UnescapeScoreboard;
   typedef struct packed {
      logic [7:0] data;
      logic       bval;
      logic       last;
   } beat_type;

   jsu_pkg::mode_type mode;
   bit [2:0]          hex_cnt;
   bit [7:0]          held [3];
   beat_type          step_out [$];
   beat_type          expected_bytes [$];
   int                errors;

   function new();
      mode    = jsu_pkg::MODE_TEXT;
      hex_cnt = 3'd0;
      errors  = 0;
   endfunction

   function void add(bit [7:0] c);
      beat_type e;
      if (step_out.size() < 3) begin
         e.data = c;
         e.bval = 1'b1;
         e.last = 1'b0;
         step_out.push_back(e);
      end
   endfunction

   // character after a backslash; 1 when it opens a u escape
   function bit after_bslash(bit [7:0] c);
      if (c == jsu_pkg::CHAR_N || c == jsu_pkg::CHAR_T) begin
         add(jsu_pkg::CHAR_SPACE);
      end else if (c == jsu_pkg::CHAR_U) begin
         return 1'b1;
      end else if (c != jsu_pkg::CHAR_R) begin
         add(c);
      end
      return 1'b0;
   endfunction

   function void note_req(bit [7:0] b, bit last);
      bit [2:0]  cnt;
      bit [15:0] code;
      bit        digits_ok;
      bit [7:0]  d [4];
      int        j;
      beat_type  e;
      step_out.delete();
      case (mode)
         jsu_pkg::MODE_ESC: begin
            mode = jsu_pkg::MODE_TEXT;
            if (after_bslash(b)) begin
               mode    = jsu_pkg::MODE_HEX;
               hex_cnt = 3'd0;
            end
         end
         jsu_pkg::MODE_HEX: begin
            cnt = hex_cnt;
            if (cnt < jsu_pkg::HEX_HOLD) begin
               held[cnt] = b;
               hex_cnt   = cnt + 3'd1;
               if (last) begin
                  // escape cut short: held text is rescanned, an inner u is lost
                  j = 0;
                  while (j <= int'(cnt)) begin
                     if (held[j] != jsu_pkg::CHAR_BSLASH || j + 1 > int'(cnt)) begin
                        add(held[j]);
                     end else begin
                        j++;
                        void'(after_bslash(held[j]));
                     end
                     j++;
                  end
               end
            end else begin
               d[0] = held[0];
               d[1] = held[1];
               d[2] = held[2];
               d[3] = b;
               code = 16'd0;
               digits_ok = 1'b1;
               for (int k = 0; k < 4; k++) begin
                  if (digits_ok) begin
                     if (d[k] >= 8'h30 && d[k] <= 8'h39)
                        code = {code[11:0], 4'(d[k] - 8'h30)};
                     else if (d[k] >= 8'h61 && d[k] <= 8'h66)
                        code = {code[11:0], 4'(d[k] - 8'h57)};
                     else if (d[k] >= 8'h41 && d[k] <= 8'h46)
                        code = {code[11:0], 4'(d[k] - 8'h37)};
                     else
                        digits_ok = 1'b0;
                  end
               end
               if (code < 16'h0080) begin
                  if (code != CP_TAB) add(code[7:0]);
               end else if (code < 16'h0800) begin
                  add(8'hC0 | {3'd0, code[10:6]});
                  add(8'h80 | {2'd0, code[5:0]});
               end else begin
                  add(8'hE0 | {4'd0, code[15:12]});
                  add(8'h80 | {2'd0, code[11:6]});
                  add(8'h80 | {2'd0, code[5:0]});
               end
               mode    = jsu_pkg::MODE_TEXT;
               hex_cnt = 3'd0;
            end
         end
         default: begin
            mode = jsu_pkg::MODE_TEXT;
            if (b == jsu_pkg::CHAR_BSLASH && !last) mode = jsu_pkg::MODE_ESC;
            else add(b);
         end
      endcase
      if (last) begin
         if (step_out.size() == 0) begin
            e.data = 8'h00;
            e.bval = 1'b0;
            e.last = 1'b1;
            step_out.push_back(e);
         end else begin
            step_out[step_out.size() - 1].last = 1'b1;
         end
         mode    = jsu_pkg::MODE_TEXT;
         hex_cnt = 3'd0;
      end
      foreach (step_out[i]) expected_bytes.push_back(step_out[i]);
   endfunction

   function void check_rsp(logic [7:0] data, logic bval, logic last);
      beat_type e;
      if (expected_bytes.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("unexpected beat: byte=%02h bv=%0d last=%0d", data, bval, last);
         return;
      end
      e = expected_bytes.pop_front();
      if (data !== e.data || bval !== e.bval || last !== e.last) begin
         errors++;
         if (errors <= 10)
            $display("mismatch: exp byte=%02h bv=%0d last=%0d, got byte=%02h bv=%0d last=%0d",
                     e.data, e.bval, e.last, data, bval, last);
      end
   endfunction

   function int pending();
      return expected_bytes.size();
   endfunction
endclass

module testbench;

   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEM_TARGET = 330;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_in_last = 1'b0;
   logic       rsp_stall   = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_out_last;

   UnescapeScoreboard sb;
   bit         idle_en = 1'b1;
   int         stall_left = 0;
   int         cycle_cnt = 0;
   int         items_sent = 0;
   logic [7:0] str_buf [$];

   json_string_unescape_utf8 u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_in_last    (req_in_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_out_last   (rsp_out_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_req(req_in_byte, req_in_last);
         if (rsp_valid && !rsp_stall)
            sb.check_rsp(rsp_out_byte, rsp_byte_valid, rsp_out_last);
      end
   end

   // receiver stalls in bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_en && $urandom_range(0, 6) == 0) begin
         stall_left = $urandom_range(1, 14) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      while (cycle_cnt < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   task send_beat(input logic [7:0] b, input logic last);
      int gap;
      if (idle_en && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task send_buf();
      foreach (str_buf[i]) send_beat(str_buf[i], i == str_buf.size() - 1);
   endtask

   task send_text(input string s);
      str_buf.delete();
      for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
      send_buf();
   endtask

   // wait on the clock first so the last accepted beat has been noted
   task wait_drained();
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // mostly well-formed escapes with random content, some raw bytes and cut-off endings
   task send_random_string();
      int        n_tok;
      int        kind;
      bit [15:0] cp;
      bit [3:0]  nib;
      bit        upper;
      logic [7:0] ch;
      str_buf.delete();
      n_tok = $urandom_range(1, 6);
      for (int t = 0; t < n_tok; t++) begin
         kind = $urandom_range(0, 9);
         if (kind <= 2) begin
            str_buf.push_back(8'($urandom_range(32, 126)));
         end else if (kind == 3) begin
            str_buf.push_back(8'($urandom_range(0, 255)));
         end else if (kind <= 5) begin
            str_buf.push_back(jsu_pkg::CHAR_BSLASH);
            case ($urandom_range(0, 6))
               0: ch = jsu_pkg::CHAR_N;
               1: ch = jsu_pkg::CHAR_T;
               2: ch = jsu_pkg::CHAR_R;
               3: ch = jsu_pkg::CHAR_BSLASH;
               4: ch = 8'h22;
               5: ch = 8'h2F;
               default: ch = 8'($urandom_range(0, 255));
            endcase
            str_buf.push_back(ch);
         end else begin
            str_buf.push_back(jsu_pkg::CHAR_BSLASH);
            str_buf.push_back(jsu_pkg::CHAR_U);
            cp = 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 2) == 0) begin
               case ($urandom_range(0, 7))
                  0: cp = CP_TAB;
                  1: cp = 16'h0000;
                  2: cp = 16'h007F;
                  3: cp = 16'h0080;
                  4: cp = 16'h07FF;
                  5: cp = 16'h0800;
                  6: cp = 16'hFFFF;
                  default: cp = 16'($urandom_range(0, 16'h07FF));
               endcase
            end
            upper = 1'($urandom_range(0, 1));
            for (int k = 0; k < 4; k++) begin
               nib = cp[15 - 4 * k -: 4];
               if (nib < 4'd10) ch = 8'h30 + nib;
               else ch = (upper ? 8'h37 : 8'h57) + nib;
               if ($urandom_range(0, 11) == 0) ch = 8'($urandom_range(0, 255));
               str_buf.push_back(ch);
            end
         end
      end
      // broken endings: lone backslash or a u escape cut short
      case ($urandom_range(0, 7))
         0: str_buf.push_back(jsu_pkg::CHAR_BSLASH);
         1, 2: begin
            str_buf.push_back(jsu_pkg::CHAR_BSLASH);
            str_buf.push_back(jsu_pkg::CHAR_U);
            kind = $urandom_range(0, 3);
            for (int k = 0; k < kind; k++) begin
               case ($urandom_range(0, 3))
                  0: str_buf.push_back(jsu_pkg::CHAR_BSLASH);
                  1: str_buf.push_back(jsu_pkg::CHAR_U);
                  2: str_buf.push_back(8'($urandom_range(8'h30, 8'h39)));
                  default: str_buf.push_back(8'($urandom_range(0, 255)));
               endcase
            end
         end
         default: ;
      endcase
      send_buf();
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      str_buf = '{8'h00};
      send_buf();
      str_buf = '{8'hFF};
      send_buf();
      send_text("\\n\\t\\r");
      send_text("\\u20AC");
      send_text("\\u\\n");
      send_text("x\\");
      send_text("\\u");
      send_text("\\r");

      req_valid <= 1'b0;
      wait_drained();

      while (items_sent < ITEM_TARGET) begin
         if (items_sent > ITEM_TARGET - 60) idle_en = 1'b0;
         send_random_string();
         if (items_sent > ITEM_TARGET / 2 && items_sent < ITEM_TARGET / 2 + 20) begin
            req_valid <= 1'b0;
            wait_drained();
         end
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
